@@ hw/rtl/critically_damped_smoother_3d_core_defines.svh @@
// assertion macros used by the checker
`ifndef CRITICALLY_DAMPED_SMOOTHER_3D_CORE_DEFINES_SVH
`define CRITICALLY_DAMPED_SMOOTHER_3D_CORE_DEFINES_SVH

// antecedent holds, consequent in the next cycle
`define CDSM_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error(msg);

// antecedent and consequent in the same cycle
`define CDSM_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error(msg);

`endif

@@ hw/rtl/cdsm_pkg.sv @@
package cdsm_pkg;

	localparam int FRAC_BITS = 16;
	localparam int DT_BITS   = 16;
	localparam int MAG_W     = 63;
	localparam int DIGIT     = 16;
	localparam int NDIG      = (MAG_W + DIGIT - 1) / DIGIT;
	localparam int K_W       = $clog2(NDIG);
	localparam int PROD_W    = 2 * MAG_W;
	localparam int QB        = FRAC_BITS + 1;
	localparam int DSH_W     = MAG_W + QB - 1;
	localparam int CNT_W     = $clog2(QB);
	localparam int NAXES     = 3;
	localparam int AX_W      = 2;
	localparam int DOT_W     = 68;

	localparam logic [MAG_W-1:0] ONE_Q = MAG_W'(1) << FRAC_BITS;
	localparam logic [MAG_W-1:0] SATU  = MAG_W'(1) << 62;
	localparam logic [MAG_W-1:0] C048  =
		MAG_W'(((((64'd48 << (FRAC_BITS + 1)) / 64'd100) + 64'd1) / 64'd2));
	localparam logic [MAG_W-1:0] C0235 =
		MAG_W'(((((64'd235 << (FRAC_BITS + 1)) / 64'd1000) + 64'd1) / 64'd2));

	localparam logic REG_ENABLE = 1'b0;
	localparam logic REG_OMEGA  = 1'b1;

	typedef enum logic [3:0] {
		OP_X, OP_X2, OP_X3, OP_T48, OP_T235,
		OP_M1, OP_TMP, OP_M3, OP_NV, OP_NO, OP_DOT
	} op_t;

	typedef struct packed {
		op_t             op;
		logic [AX_W-1:0] ax;
		logic            load;
		logic            mul_start;
		logic            div_start;
		logic            commit;
		logic            hold;
	} cmd_t;

	typedef struct packed {
		logic mul_done;
		logic div_done;
		logic out_full;
	} sts_t;

	function automatic logic signed [63:0] sadd(input logic signed [63:0] a,
		input logic signed [63:0] b);
		logic signed [64:0] s;
		logic signed [64:0] lim;
		lim = 65'sh0_4000_0000_0000_0000;
		s = 65'(a) + 65'(b);
		if (s > lim) return 64'sh4000_0000_0000_0000;
		if (s < -lim) return -64'sh4000_0000_0000_0000;
		return s[63:0];
	endfunction

	function automatic logic [MAG_W-1:0] uadd(input logic [MAG_W-1:0] a,
		input logic [MAG_W-1:0] b);
		logic [MAG_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s > {1'b0, SATU}) return SATU;
		return s[MAG_W-1:0];
	endfunction

	function automatic logic [MAG_W-1:0] mag64(input logic signed [63:0] v);
		logic [63:0] n;
		n = (v < 0) ? -v : v;
		return n[MAG_W-1:0];
	endfunction

	function automatic logic signed [63:0] apply_sign(input logic [MAG_W-1:0] m,
		input logic neg);
		logic signed [63:0] p;
		p = $signed({1'b0, m});
		return neg ? -p : p;
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		if (v > 64'sd2147483647) return 32'sh7fff_ffff;
		if (v < -64'sd2147483648) return 32'sh8000_0000;
		return v[31:0];
	endfunction

endpackage

@@ hw/rtl/cdsm_mul.sv @@
module cdsm_mul (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic                        shift_dt,
	input  logic [cdsm_pkg::MAG_W-1:0]  a,
	input  logic [cdsm_pkg::MAG_W-1:0]  b,
	output logic [cdsm_pkg::MAG_W-1:0]  res,
	output logic [cdsm_pkg::PROD_W-1:0] prod,
	output logic                        done
);
	import cdsm_pkg::*;

	localparam logic [PROD_W:0] HALF_F = (PROD_W + 1)'(1) << (FRAC_BITS - 1);
	localparam logic [PROD_W:0] HALF_D = (PROD_W + 1)'(1) << (DT_BITS - 1);

	logic [MAG_W-1:0]  a_q, b_q, res_q;
	logic [PROD_W-1:0] acc_q;
	logic [K_W-1:0]    k_q;
	logic              sel_q, run_q, rnd_q, done_q;
	logic [MAG_W+DIGIT-1:0] part;
	logic [MAG_W-1:0]  b_nx;
	logic [PROD_W:0]   sum, shifted;

	// one 16-bit digit of b per cycle
	assign part    = a_q * b_q[DIGIT-1:0];
	assign b_nx    = b_q >> DIGIT;
	assign sum     = {1'b0, acc_q} + (sel_q ? HALF_D : HALF_F);
	assign shifted = sel_q ? (sum >> DT_BITS) : (sum >> FRAC_BITS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			rnd_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= rnd_q;
			rnd_q  <= run_q && (b_nx == '0);
			if (start) run_q <= 1'b1;
			else if (run_q && (b_nx == '0)) run_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= a;
			b_q   <= b;
			acc_q <= '0;
			k_q   <= '0;
			sel_q <= shift_dt;
		end else if (run_q) begin
			acc_q <= acc_q + (PROD_W'(part) << (DIGIT * k_q));
			b_q   <= b_nx;
			k_q   <= k_q + K_W'(1);
		end
		if (rnd_q) res_q <= (shifted > (PROD_W + 1)'(SATU)) ? SATU : shifted[MAG_W-1:0];
	end

	assign res  = res_q;
	assign prod = acc_q;
	assign done = done_q;
endmodule

@@ hw/rtl/cdsm_dp.sv @@
module cdsm_dp (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cdsm_pkg::cmd_t       cmd,
	output cdsm_pkg::sts_t       sts,
	input  logic [31:0]          omega,
	input  logic [15:0]          in_time_step,
	input  logic signed [31:0]   in_target [3],
	input  logic                 out_ready,
	output logic                 out_valid,
	output logic signed [31:0]   out_pos [3],
	output logic                 out_snapped
);
	import cdsm_pkg::*;

	logic [15:0]         dt_q;
	logic signed [31:0]  tgt_q [NAXES];
	logic signed [31:0]  pos_q [NAXES];
	logic signed [31:0]  vel_q [NAXES];
	logic signed [31:0]  nvel_q [NAXES];
	logic signed [31:0]  nout_q [NAXES];
	logic [MAG_W-1:0]    x_q, x2_q, x3_q, d_q;
	logic signed [63:0]  a_q, tmp_q, v_q;
	logic signed [DOT_W-1:0] dot_q;
	logic                neg_q;

	logic [63:0]         rem_q;
	logic [DSH_W-1:0]    dsh_q;
	logic [QB-1:0]       quo_q;
	logic [CNT_W-1:0]    cnt_q;
	logic                div_run_q, div_done_q;

	logic signed [31:0]  pos_a, tgt_a, vel_a, nout_a;
	logic signed [63:0]  chg, sct, qv, sres;
	logic [MAG_W-1:0]    ma, mb, res;
	logic [PROD_W-1:0]   prod;
	logic                shift_dt, neg, mul_done, ge, snap;
	logic signed [DOT_W-1:0] pe;

	assign pos_a  = pos_q[cmd.ax];
	assign tgt_a  = tgt_q[cmd.ax];
	assign vel_a  = vel_q[cmd.ax];
	assign nout_a = nout_q[cmd.ax];
	assign chg    = 64'(pos_a) - 64'(tgt_a);
	assign sct    = sadd(chg, tmp_q);
	assign qv     = 64'(nout_a) - 64'(tgt_a);

	always_comb begin
		ma = '0;
		mb = '0;
		shift_dt = 1'b0;
		neg = 1'b0;
		case (cmd.op)
			OP_X: begin
				ma = MAG_W'(omega);
				mb = MAG_W'(dt_q);
				shift_dt = 1'b1;
			end
			OP_X2: begin
				ma = x_q;
				mb = x_q;
			end
			OP_X3: begin
				ma = x2_q;
				mb = x_q;
			end
			OP_T48: begin
				ma = C048;
				mb = x2_q;
			end
			OP_T235: begin
				ma = C0235;
				mb = x3_q;
			end
			OP_M1: begin
				ma = mag64(chg);
				mb = MAG_W'(omega);
				neg = chg < 0;
			end
			OP_TMP: begin
				ma = mag64(a_q);
				mb = MAG_W'(dt_q);
				shift_dt = 1'b1;
				neg = a_q < 0;
			end
			OP_M3: begin
				// subtracted term: sign flipped
				ma = mag64(tmp_q);
				mb = MAG_W'(omega);
				neg = !(tmp_q < 0);
			end
			OP_NV: begin
				ma = mag64(v_q);
				mb = MAG_W'(quo_q);
				neg = v_q < 0;
			end
			OP_NO: begin
				ma = mag64(sct);
				mb = MAG_W'(quo_q);
				neg = sct < 0;
			end
			OP_DOT: begin
				ma = mag64(chg);
				mb = mag64(qv);
				neg = (chg > 0) != (qv < 0);
			end
			default: begin
				ma = '0;
			end
		endcase
	end

	cdsm_mul u_mul (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.mul_start),
		.shift_dt (shift_dt),
		.a        (ma),
		.b        (mb),
		.res      (res),
		.prod     (prod),
		.done     (mul_done)
	);

	assign sres = apply_sign(res, neg_q);
	assign pe   = $signed({3'b000, prod[64:0]});
	assign ge   = {{(DSH_W - 64){1'b0}}, rem_q} >= dsh_q;
	assign snap = dot_q > 0;

	// restoring divider for the decay factor
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_run_q  <= 1'b0;
			div_done_q <= 1'b0;
		end else begin
			div_done_q <= div_run_q && (cnt_q == '0);
			if (cmd.div_start) div_run_q <= 1'b1;
			else if (div_run_q && (cnt_q == '0)) div_run_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			rem_q <= (64'(1) << (2 * FRAC_BITS)) + 64'(d_q >> 1);
			dsh_q <= {d_q, {(QB - 1){1'b0}}};
			quo_q <= '0;
			cnt_q <= CNT_W'(QB - 1);
		end else if (div_run_q) begin
			if (ge) rem_q <= rem_q - dsh_q[63:0];
			quo_q <= {quo_q[QB-2:0], ge};
			dsh_q <= dsh_q >> 1;
			cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			dt_q  <= in_time_step;
			tgt_q <= in_target;
			dot_q <= '0;
		end
		if (cmd.mul_start) neg_q <= neg;
		if (mul_done) begin
			case (cmd.op)
				OP_X: begin
					x_q <= res;
					d_q <= uadd(ONE_Q, res);
				end
				OP_X2:   x2_q <= res;
				OP_X3:   x3_q <= res;
				OP_T48:  d_q <= uadd(d_q, res);
				OP_T235: d_q <= uadd(d_q, res);
				OP_M1:   a_q <= sadd(64'(vel_a), sres);
				OP_TMP:  tmp_q <= sres;
				OP_M3:   v_q <= sadd(64'(vel_a), sres);
				OP_NV:   nvel_q[cmd.ax] <= sat32(sres);
				OP_NO:   nout_q[cmd.ax] <= sat32(sadd(64'(tgt_a), sres));
				OP_DOT:  dot_q <= dot_q + (neg_q ? -pe : pe);
				default: dot_q <= dot_q;
			endcase
		end
		if (cmd.commit) begin
			if (cmd.hold) begin
				out_pos     <= pos_q;
				out_snapped <= 1'b0;
			end else begin
				out_pos     <= snap ? tgt_q : nout_q;
				out_snapped <= snap;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
			for (int i = 0; i < NAXES; i++) begin
				pos_q[i] <= '0;
				vel_q[i] <= '0;
			end
		end else begin
			if (cmd.commit) out_valid <= 1'b1;
			else if (out_ready) out_valid <= 1'b0;
			if (cmd.commit && !cmd.hold) begin
				for (int i = 0; i < NAXES; i++) begin
					pos_q[i] <= snap ? tgt_q[i] : nout_q[i];
					vel_q[i] <= snap ? 32'sd0 : nvel_q[i];
				end
			end
		end
	end

	assign sts.mul_done = mul_done;
	assign sts.div_done = div_done_q;
	assign sts.out_full = out_valid && !out_ready;
endmodule

@@ hw/rtl/cdsm_ctrl.sv @@
module cdsm_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           enable,
	input  logic           in_valid,
	output logic           in_ready,
	input  cdsm_pkg::sts_t sts,
	output cdsm_pkg::cmd_t cmd
);
	import cdsm_pkg::*;

	typedef enum logic [14:0] {
		S_IDLE   = 15'd1,
		S_X      = 15'd2,
		S_X2     = 15'd4,
		S_X3     = 15'd8,
		S_T48    = 15'd16,
		S_T235   = 15'd32,
		S_DIV    = 15'd64,
		S_M1     = 15'd128,
		S_TMP    = 15'd256,
		S_M3     = 15'd512,
		S_NV     = 15'd1024,
		S_NO     = 15'd2048,
		S_DOT    = 15'd4096,
		S_COMMIT = 15'd8192,
		S_HOLD   = 15'd16384
	} state_t;

	state_t          state_q, state_d, succ;
	op_t             op_d;
	logic            launched_q, launch_d;
	logic [AX_W-1:0] ax_q, ax_d;

	always_comb begin
		op_d = OP_X;
		succ = S_IDLE;
		case (state_q)
			S_X: begin
				op_d = OP_X;
				succ = S_X2;
			end
			S_X2: begin
				op_d = OP_X2;
				succ = S_X3;
			end
			S_X3: begin
				op_d = OP_X3;
				succ = S_T48;
			end
			S_T48: begin
				op_d = OP_T48;
				succ = S_T235;
			end
			S_T235: begin
				op_d = OP_T235;
				succ = S_DIV;
			end
			S_M1: begin
				op_d = OP_M1;
				succ = S_TMP;
			end
			S_TMP: begin
				op_d = OP_TMP;
				succ = S_M3;
			end
			S_M3: begin
				op_d = OP_M3;
				succ = S_NV;
			end
			S_NV: begin
				op_d = OP_NV;
				succ = S_NO;
			end
			S_NO: begin
				op_d = OP_NO;
				succ = S_DOT;
			end
			S_DOT: begin
				op_d = OP_DOT;
				succ = (ax_q == AX_W'(NAXES - 1)) ? S_COMMIT : S_M1;
			end
			default: begin
				op_d = OP_X;
			end
		endcase
	end

	always_comb begin
		state_d       = state_q;
		launch_d      = launched_q;
		ax_d          = ax_q;
		in_ready      = 1'b0;
		cmd.op        = op_d;
		cmd.ax        = ax_q;
		cmd.load      = 1'b0;
		cmd.mul_start = 1'b0;
		cmd.div_start = 1'b0;
		cmd.commit    = 1'b0;
		cmd.hold      = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					ax_d = '0;
					state_d = enable ? S_X : S_HOLD;
				end
			end
			S_X, S_X2, S_X3, S_T48, S_T235, S_M1, S_TMP, S_M3, S_NV, S_NO, S_DOT: begin
				if (!launched_q) begin
					cmd.mul_start = 1'b1;
					launch_d = 1'b1;
				end else if (sts.mul_done) begin
					launch_d = 1'b0;
					state_d = succ;
					if (state_q == S_DOT)
						ax_d = (succ == S_M1) ? ax_q + AX_W'(1) : '0;
				end
			end
			S_DIV: begin
				if (!launched_q) begin
					cmd.div_start = 1'b1;
					launch_d = 1'b1;
				end else if (sts.div_done) begin
					launch_d = 1'b0;
					state_d = S_M1;
				end
			end
			S_COMMIT, S_HOLD: begin
				if (!sts.out_full) begin
					cmd.commit = 1'b1;
					cmd.hold = (state_q == S_HOLD);
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
				launch_d = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			launched_q <= 1'b0;
			ax_q       <= '0;
		end else begin
			state_q    <= state_d;
			launched_q <= launch_d;
			ax_q       <= ax_d;
		end
	end
endmodule

@@ hw/rtl/critically_damped_smoother_3d_core.sv @@
// critically damped 3-d smoother, one item in flight at a time
// enabled item: computed by the shared 63x16 multiplier (23 products, one 16-bit digit of b
// per multiplier step) and a 17-step divider; a new item is taken only after the last commits
// disabled item: the hold state re-issues the held position once the output is not full
// arst_n clears position, velocity and handshake state; enable resets to 1, omega to 2.0
module critically_damped_smoother_3d_core (
	input  logic         clk,
	input  logic         arst_n,
	// config port
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [2:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready,
	// input items
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [111:0] s_tdata,  // time_step, target_x, target_y, target_z
	// result items
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [95:0]  m_tdata,  // out_x, out_y, out_z
	output logic         m_tuser   // snapped
);
	import cdsm_pkg::*;

	logic               enable_q;
	logic [31:0]        omega_q;
	cmd_t               cmd;
	sts_t               sts;
	logic signed [31:0] in_target [3];
	logic signed [31:0] out_pos [3];

	// register file: enable at 0x0, omega at 0x4
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b1;
			omega_q  <= 32'h0002_0000;
		end else if (psel && penable && pwrite && pready) begin
			if (paddr[2] == REG_ENABLE) enable_q <= pwdata[0];
			else omega_q <= pwdata;
		end
	end

	assign prdata = (paddr[2] == REG_OMEGA) ? omega_q : {31'd0, enable_q};

	// unpack the input item
	assign in_target[0] = s_tdata[47:16];
	assign in_target[1] = s_tdata[79:48];
	assign in_target[2] = s_tdata[111:80];

	cdsm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.enable   (enable_q),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// shared multiplier, divider and the smoother state live in the datapath
	cdsm_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.omega        (omega_q),
		.in_time_step (s_tdata[15:0]),
		.in_target    (in_target),
		.out_ready    (m_tready),
		.out_valid    (m_tvalid),
		.out_pos      (out_pos),
		.out_snapped  (m_tuser)
	);

	// pack the result item
	assign m_tdata = {out_pos[2], out_pos[1], out_pos[0]};
endmodule

@@ hw/rtl/cdsm_checker.sv @@
`include "critically_damped_smoother_3d_core_defines.svh"

module cdsm_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         pready,
	input logic         s_tvalid,
	input logic         s_tready,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [95:0]  m_tdata,
	input logic         m_tuser
);
	// a stalled result keeps its payload
	`CDSM_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")
	// one item at a time: ready drops right after an accept
	`CDSM_ASSERT_NEXT(a_one_item, clk, arst_n, s_tvalid && s_tready, !s_tready, "second item taken while busy")
	// no result appears in the cycle right after an accept
	`CDSM_ASSERT_NEXT(a_no_early, clk, arst_n, s_tvalid && s_tready, !$rose(m_tvalid), "result too early")
	// config port never stalls
	`CDSM_ASSERT_NOW(a_pready, clk, arst_n, 1'b1, pready, "pready low")
endmodule

bind critically_damped_smoother_3d_core cdsm_checker u_cdsm_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.pready   (pready),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

@@ tb/critically_damped_smoother_3d_core_tb.sv @@
`timescale 1ns / 1ps

module critically_damped_smoother_3d_core_tb;

	import cdsm_pkg::*;

	// register byte addresses
	typedef enum logic [2:0] {
		ADDR_ENABLE = 3'd0,
		ADDR_OMEGA  = 3'd4
	} reg_addr_t;

	typedef struct {
		logic [15:0]        dt;
		logic signed [31:0] tgt [3];
	} step_item_t;

	typedef struct {
		logic signed [31:0] pos [3];
		logic               snap;
	} pos_result_t;

	localparam logic [63:0] SAT_MAG = 64'd1 << 62;
	localparam logic [63:0] Q_ONE   = 64'd1 << FRAC_BITS;
	localparam logic [63:0] K048    = ((((64'd48 << (FRAC_BITS + 1)) / 64'd100) + 64'd1) / 64'd2);
	localparam logic [63:0] K0235   = ((((64'd235 << (FRAC_BITS + 1)) / 64'd1000) + 64'd1) / 64'd2);

	// spring state mirror and queue of predicted positions
	class smoother_scoreboard;
		bit          en;
		logic [31:0] w;
		longint      pos [3];
		longint      vel [3];
		pos_result_t pending_pos [$];
		int          mismatches;

		function new();
			en = 1'b1;
			w = 32'd131072;
			for (int i = 0; i < 3; i++) begin
				pos[i] = 0;
				vel[i] = 0;
			end
			mismatches = 0;
		endfunction

		function void set_reg(reg_addr_t a, logic [31:0] v);
			if (a == ADDR_ENABLE) en = v[0];
			else w = v;
		endfunction

		// round(a*b / 2^s), saturated magnitude
		function logic [63:0] mul_rnd(logic [63:0] a, logic [63:0] b, int s);
			logic [128:0] p;
			p = 129'(a) * 129'(b) + (129'(1) << (s - 1));
			p = p >> s;
			return (p > 129'(SAT_MAG)) ? SAT_MAG : p[63:0];
		endfunction

		function longint smul(longint a, logic [63:0] b, int s);
			logic [63:0] m;
			longint r;
			m = (a < 0) ? -a : a;
			r = mul_rnd(m, b, s);
			return (a < 0) ? -r : r;
		endfunction

		function longint clamp62(longint v);
			if (v > longint'(SAT_MAG)) return longint'(SAT_MAG);
			if (v < -longint'(SAT_MAG)) return -longint'(SAT_MAG);
			return v;
		endfunction

		function longint clamp32(longint v);
			if (v > 64'sd2147483647) return 64'sd2147483647;
			if (v < -64'sd2147483648) return -64'sd2147483648;
			return v;
		endfunction

		function logic [63:0] usat(logic [63:0] a, logic [63:0] b);
			logic [64:0] s;
			s = 65'(a) + 65'(b);
			return (s > 65'(SAT_MAG)) ? SAT_MAG : s[63:0];
		endfunction

		function void note_input(step_item_t it);
			pos_result_t r;
			logic [63:0] x, x2, x3, d, ex, dt;
			longint tg [3], nout [3], nvel [3];
			longint chg, acc, tmp, v;
			logic signed [127:0] dot, pp, qq;
			bit snap;
			dt = 64'(it.dt);
			for (int i = 0; i < 3; i++) tg[i] = it.tgt[i];
			if (!en) begin
				// frozen: repeat the held position
				for (int i = 0; i < 3; i++) r.pos[i] = pos[i][31:0];
				r.snap = 1'b0;
				pending_pos.push_back(r);
				return;
			end
			x = mul_rnd(64'(w), dt, 16);
			x2 = mul_rnd(x, x, FRAC_BITS);
			x3 = mul_rnd(x2, x, FRAC_BITS);
			d = usat(Q_ONE, x);
			d = usat(d, mul_rnd(K048, x2, FRAC_BITS));
			d = usat(d, mul_rnd(K0235, x3, FRAC_BITS));
			ex = ((Q_ONE << FRAC_BITS) + d / 2) / d;
			for (int i = 0; i < 3; i++) begin
				chg = pos[i] - tg[i];
				acc = clamp62(vel[i] + smul(chg, 64'(w), FRAC_BITS));
				tmp = smul(acc, dt, 16);
				v = clamp62(vel[i] - smul(tmp, 64'(w), FRAC_BITS));
				nvel[i] = clamp32(smul(v, ex, FRAC_BITS));
				nout[i] = clamp32(clamp62(tg[i] + smul(clamp62(chg + tmp), ex, FRAC_BITS)));
			end
			// overshoot test on the exact dot product
			dot = 0;
			for (int i = 0; i < 3; i++) begin
				pp = tg[i] - pos[i];
				qq = nout[i] - tg[i];
				dot += pp * qq;
			end
			snap = (dot > 0);
			for (int i = 0; i < 3; i++) begin
				pos[i] = snap ? tg[i] : nout[i];
				vel[i] = snap ? 0 : nvel[i];
				r.pos[i] = pos[i][31:0];
			end
			r.snap = snap;
			pending_pos.push_back(r);
		endfunction

		function void check_result(logic [95:0] data, logic snapped);
			pos_result_t e;
			bit bad;
			if (pending_pos.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result item %h %b", data, snapped);
				return;
			end
			e = pending_pos.pop_front();
			bad = (snapped !== e.snap);
			for (int i = 0; i < 3; i++)
				if (data[32*i +: 32] !== e.pos[i]) bad = 1;
			if (bad) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: exp x=%h y=%h z=%h snap=%b, got x=%h y=%h z=%h snap=%b",
						e.pos[0], e.pos[1], e.pos[2], e.snap,
						data[31:0], data[63:32], data[95:64], snapped);
			end
		endfunction
	endclass

	logic         clk;
	logic         arst_n;
	logic         psel, penable, pwrite;
	logic [2:0]   paddr;
	logic [31:0]  pwdata, prdata;
	logic         pready;
	logic         s_tvalid, s_tready;
	logic [111:0] s_tdata;  // time_step, target_x, target_y, target_z
	logic         m_tvalid, m_tready;
	logic [95:0]  m_tdata;  // out_x, out_y, out_z
	logic         m_tuser;  // snapped

	smoother_scoreboard sb;
	bit calm;       // no idling on either side
	bit hold_req;   // receiver long hold-off request
	bit done;

	critically_damped_smoother_3d_core u_top (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// apb write: setup then access
	task automatic write_reg(reg_addr_t a, logic [31:0] v);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= a;
		pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		sb.set_reg(a, v);
	endtask

	// offer one item and hold it until accepted
	task automatic send_step(step_item_t it);
		if (!calm) begin
			while ($urandom_range(99) < 22) begin
				s_tvalid <= 1'b0;
				@(posedge clk);
			end
		end
		s_tvalid <= 1'b1;
		s_tdata <= {it.tgt[2], it.tgt[1], it.tgt[0], it.dt};
		do @(posedge clk); while (!s_tready);
		sb.note_input(it);
	endtask

	task automatic idle_send();
		s_tvalid <= 1'b0;
		@(posedge clk);
	endtask

	// wait for every expected item, then let the block settle
	task automatic drain();
		idle_send();
		while (sb.pending_pos.size() != 0) @(posedge clk);
		repeat (160) @(posedge clk);
	endtask

	function automatic step_item_t pick_step(bit wild);
		step_item_t it;
		if (wild) begin
			it.dt = $urandom_range(65535);
			for (int i = 0; i < 3; i++) it.tgt[i] = $urandom;
		end else begin
			// moderate step and nearby goal, so overshoot happens now and then
			it.dt = ($urandom_range(3) == 0) ? $urandom_range(65535) : $urandom_range(4000);
			for (int i = 0; i < 3; i++)
				it.tgt[i] = $signed(32'($urandom_range(2097152))) - 32'sd1048576;
		end
		return it;
	endfunction

	function automatic step_item_t make_step(logic [15:0] dt, logic [31:0] a, logic [31:0] b,
		logic [31:0] c);
		step_item_t it;
		it.dt = dt;
		it.tgt[0] = a;
		it.tgt[1] = b;
		it.tgt[2] = c;
		return it;
	endfunction

	// result side: random back-pressure, one long hold-off on request
	initial begin
		m_tready = 1'b0;
		@(posedge arst_n);
		while (!done) begin
			if (hold_req) begin
				m_tready <= 1'b0;
				repeat (400) @(posedge clk);
				hold_req = 1'b0;
			end
			m_tready <= calm || ($urandom_range(99) >= 22);
			@(posedge clk);
			if (m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser);
		end
	end

	initial begin
		logic [31:0] w_set [8];
		sb = new();
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		calm = 1'b0;
		hold_req = 1'b0;
		done = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: field extremes at reset settings
		send_step(make_step(16'd0, 32'h7fff_ffff, 32'h8000_0000, 32'd0));
		send_step(make_step(16'hffff, 32'h7fff_ffff, 32'h8000_0000, 32'd0));
		send_step(make_step(16'hffff, 32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff));
		send_step(make_step(16'd1, 32'd0, 32'd0, 32'd0));
		// far goal then jump back, velocity carries past the goal
		send_step(make_step(16'd3000, 32'h0010_0000, 32'h0010_0000, 32'h0010_0000));
		send_step(make_step(16'd3000, 32'h0010_0000, 32'h0010_0000, 32'h0010_0000));
		send_step(make_step(16'd20000, 32'd0, 32'd0, 32'd0));
		send_step(make_step(16'd20000, 32'hfff0_0000, 32'd0, 32'h0001_0000));
		drain();
		// huge stiffness: denominator saturates
		write_reg(ADDR_OMEGA, 32'hffff_ffff);
		send_step(make_step(16'hffff, 32'h1234_5678, 32'h8000_0000, 32'h7fff_ffff));
		send_step(make_step(16'd1, 32'h0000_1000, 32'hffff_0000, 32'd5));
		send_step(make_step(16'd0, 32'd0, 32'd0, 32'd0));
		drain();
		// zero stiffness: decay is one
		write_reg(ADDR_OMEGA, 32'd0);
		send_step(make_step(16'hffff, 32'h0100_0000, 32'hff00_0000, 32'd7));
		send_step(make_step(16'd100, 32'd0, 32'd0, 32'd0));
		drain();
		// frozen state
		write_reg(ADDR_ENABLE, 32'd0);
		send_step(make_step(16'hffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff));
		send_step(make_step(16'd0, 32'h8000_0000, 32'd0, 32'd1));
		drain();
		write_reg(ADDR_ENABLE, 32'd1);
		write_reg(ADDR_OMEGA, 32'd131072);
		send_step(make_step(16'd8000, 32'h0002_0000, 32'hfffe_0000, 32'd0));
		send_step(make_step(16'd8000, 32'h0002_0000, 32'hfffe_0000, 32'd0));
		drain();

		// random phases over stiffness settings, extremes among them
		w_set[0] = 32'd131072;
		w_set[1] = 32'hffff_ffff;
		w_set[2] = 32'd0;
		w_set[3] = 32'h0010_0000;
		w_set[4] = 32'h0000_8000;
		w_set[5] = $urandom;
		w_set[6] = $urandom_range(32'h0040_0000);
		w_set[7] = 32'h0004_0000;
		for (int ph = 0; ph < 8; ph++) begin
			write_reg(ADDR_OMEGA, w_set[ph]);
			write_reg(ADDR_ENABLE, (ph == 5) ? 32'd0 : 32'd1);
			calm = (ph == 3);
			for (int n = 0; n < 160; n++) begin
				if (ph == 2 && n == 20) hold_req = 1'b1;
				if (ph == 4 && n == 80) begin
					// sender waits for every outstanding result
					idle_send();
					while (sb.pending_pos.size() != 0) @(posedge clk);
				end
				send_step(pick_step($urandom_range(9) == 0));
			end
			drain();
		end
		calm = 1'b0;

		repeat (200) @(posedge clk);
		done = 1'b1;
		if (sb.mismatches == 0 && sb.pending_pos.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

	initial begin
		#12_000_000;
		$display("== FAIL ==");
		$finish;
	end

endmodule
